/* design/srd_pkg.sv */
// shared constants, types and helpers for the sound region detector
package srd_pkg;

	localparam int SAMPLE_BITS   = 16;
	localparam int INDEX_BITS    = 32;
	localparam int IN_BITS       = 16;
	localparam int OUT_BITS      = 32;
	localparam int THR_BITS      = 16;
	localparam int GAP_BITS      = 24;
	localparam int CFG_DATA_BITS = 24;
	localparam int CFG_IDX_BITS  = 2;

	localparam int MAG_BITS = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;
	localparam int SUM_BITS = ((INDEX_BITS > GAP_BITS) ? INDEX_BITS : GAP_BITS) + 1;

	localparam int QDEPTH    = 2;
	localparam int QPTR_BITS = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_BITS = $clog2(QDEPTH + 1);

	localparam logic [THR_BITS-1:0]   NOISE_RESET = THR_BITS'(400);
	localparam logic [GAP_BITS-1:0]   GAP_RESET   = GAP_BITS'(10000);
	localparam logic [INDEX_BITS-1:0] IDX_MAX     = {INDEX_BITS{1'b1}};

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_NOISE_THRESHOLD = CFG_IDX_BITS'(0),
		REG_MERGE_GAP       = CFG_IDX_BITS'(1)
	} srd_reg_t;

	// one queue entry holds all results of one item
	typedef struct packed {
		logic                two;
		logic [OUT_BITS-1:0] first0;
		logic [OUT_BITS-1:0] final0;
		logic [OUT_BITS-1:0] first1;
		logic [OUT_BITS-1:0] final1;
	} srd_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} srd_qstat_t;

	function automatic logic [OUT_BITS-1:0] to_out(input logic [INDEX_BITS-1:0] idx);
		return OUT_BITS'(idx);
	endfunction

endpackage

/* design/srd_front.sv */
// front end: config registers, sample classification and region tracking
module srd_front import srd_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [IN_BITS-1:0] sample_value,
	input  logic                     stream_end,
	input  srd_qstat_t               qstat,
	output logic                     push,
	output srd_entry_t               entry
);

	logic [THR_BITS-1:0]   thr_q;
	logic [GAP_BITS-1:0]   gap_q;
	logic [INDEX_BITS-1:0] count_q, raw_start_q, prev_end_q, grp_start_q;
	logic                  in_sound_q, grp_open_q;

	logic [INDEX_BITS-1:0] count_d, raw_start_d, prev_end_d, grp_start_d;
	logic                  in_sound_d, grp_open_d;

	logic [SAMPLE_BITS-1:0] raw, mag;
	logic                   loud, far, accept;
	logic                   a_v, b_v;
	logic [INDEX_BITS-1:0]  a_first, a_final, b_first, b_final, idx;

	assign in_ready = !qstat.full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		raw  = SAMPLE_BITS'($unsigned(sample_value));
		mag  = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
		loud = MAG_BITS'(mag) > MAG_BITS'(thr_q);
		idx  = count_q;
		far  = SUM_BITS'(idx) > (SUM_BITS'(prev_end_q) + SUM_BITS'(gap_q));

		count_d     = count_q;
		raw_start_d = raw_start_q;
		prev_end_d  = prev_end_q;
		grp_start_d = grp_start_q;
		in_sound_d  = in_sound_q;
		grp_open_d  = grp_open_q;
		a_v = 1'b0;
		a_first = grp_start_q;
		a_final = prev_end_q;
		b_v = 1'b0;

		if (loud && !in_sound_q) begin
			raw_start_d = idx;
			in_sound_d  = 1'b1;
			if (!grp_open_q) begin
				grp_start_d = idx;
				grp_open_d  = 1'b1;
			end else if (far) begin
				// distant region closes the open group
				a_v         = 1'b1;
				grp_start_d = idx;
			end
		end else if (!loud && in_sound_q) begin
			prev_end_d = (idx > raw_start_q) ? (idx - 1'b1) : raw_start_q;
			in_sound_d = 1'b0;
		end

		if (stream_end) begin
			if (in_sound_d) begin
				prev_end_d = idx;
			end
			b_v = grp_open_d;
		end
		b_first = grp_start_d;
		b_final = prev_end_d;

		if (stream_end) begin
			count_d     = '0;
			raw_start_d = '0;
			prev_end_d  = '0;
			grp_start_d = '0;
			in_sound_d  = 1'b0;
			grp_open_d  = 1'b0;
		end else if (idx != IDX_MAX) begin
			count_d = idx + 1'b1;
		end

		entry.two    = a_v && b_v;
		entry.first0 = to_out(a_v ? a_first : b_first);
		entry.final0 = to_out(a_v ? a_final : b_final);
		entry.first1 = to_out(b_first);
		entry.final1 = to_out(b_final);
		push = accept && (a_v || b_v);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= NOISE_RESET;
			gap_q <= GAP_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_NOISE_THRESHOLD: thr_q <= cfg_data[THR_BITS-1:0];
				REG_MERGE_GAP:       gap_q <= cfg_data[GAP_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			raw_start_q <= '0;
			prev_end_q  <= '0;
			grp_start_q <= '0;
			in_sound_q  <= 1'b0;
			grp_open_q  <= 1'b0;
		end else if (accept) begin
			count_q     <= count_d;
			raw_start_q <= raw_start_d;
			prev_end_q  <= prev_end_d;
			grp_start_q <= grp_start_d;
			in_sound_q  <= in_sound_d;
			grp_open_q  <= grp_open_d;
		end
	end

endmodule

/* design/srd_queue.sv */
// short result queue between front and back
module srd_queue import srd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  srd_entry_t din,
	input  logic       pop,
	output srd_entry_t dout,
	output srd_qstat_t qstat
);

	srd_entry_t            mem_q [QDEPTH];
	logic [QPTR_BITS-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QCNT_BITS-1:0]  cnt_q;

	function automatic logic [QPTR_BITS-1:0] step(input logic [QPTR_BITS-1:0] p);
		return (p == QPTR_BITS'(QDEPTH - 1)) ? '0 : (p + 1'b1);
	endfunction

	assign dout        = mem_q[rd_ptr_q];
	assign qstat.full  = (cnt_q == QCNT_BITS'(QDEPTH));
	assign qstat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= step(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= step(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* design/srd_back.sv */
// back end: unpacks queue entries into single result items
module srd_back import srd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  srd_entry_t          entry,
	input  srd_qstat_t          qstat,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [OUT_BITS-1:0] group_first,
	output logic [OUT_BITS-1:0] group_final,
	output logic                run_last
);

	srd_entry_t ent_q;
	logic       hold_q, sub_q;

	assign run_last    = sub_q || !ent_q.two;
	assign out_valid   = hold_q;
	assign group_first = sub_q ? ent_q.first1 : ent_q.first0;
	assign group_final = sub_q ? ent_q.final1 : ent_q.final0;
	assign pop         = !qstat.empty && (!hold_q || (out_ready && run_last));

	always_ff @(posedge clk) begin
		if (pop) begin
			ent_q <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
			sub_q  <= 1'b0;
		end else if (pop) begin
			hold_q <= 1'b1;
			sub_q  <= 1'b0;
		end else if (hold_q && out_ready) begin
			if (run_last) begin
				hold_q <= 1'b0;
			end else begin
				sub_q <= 1'b1;
			end
		end
	end

endmodule

/* design/sound_region_detector_unit.sv */
// top level of the sound region detector: front, result queue, back
// an item's results are registered into the queue, then into the back end before they show
// throughput: one item per cycle while the queue has room; two results of an item go out in turn
// the two-entry result queue sets how far the front may run ahead of a stalled output
// reset: arst_n clears all region state and the queue, and loads noise_threshold 400, merge_gap 10000
// config writes are always taken (cfg_ready stays high)
module sound_region_detector_unit import srd_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration write channel
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	// sample items in
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [IN_BITS-1:0] sample_value,
	input  logic                      stream_end,
	// group result items out
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [OUT_BITS-1:0]       group_first,
	output logic [OUT_BITS-1:0]       group_final,
	output logic                      run_last
);

	// front to queue
	logic       push;
	srd_entry_t push_entry;
	// queue to back
	srd_entry_t head_entry;
	srd_qstat_t qstat;
	logic       pop;

	assign cfg_ready = 1'b1;

	// front: classifies every sample, tracks regions and groups, packs results per item
	srd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample_value (sample_value),
		.stream_end   (stream_end),
		.qstat        (qstat),
		.push         (push),
		.entry        (push_entry)
	);

	// queue: lets the front keep taking samples while a result waits
	srd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_entry),
		.pop    (pop),
		.dout   (head_entry),
		.qstat  (qstat)
	);

	// back: drives one result item per cycle while out_ready is high and results wait, marking the last one of each sample
	srd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.entry       (head_entry),
		.qstat       (qstat),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.group_first (group_first),
		.group_final (group_final),
		.run_last    (run_last)
	);

`ifndef SYNTHESIS
	// queue cannot be full and empty at once
	a_qstat_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(qstat.full && qstat.empty))
		else $error("queue reports full and empty together");

	// a pushed entry is visible in the queue or already in the back end
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (!qstat.empty || out_valid))
		else $error("pushed entry lost");

	// the second result of an item follows the first
	a_second_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !run_last) |=> (out_valid && run_last))
		else $error("second result missing");

	// a push only happens on an accepted item
	a_push_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (in_valid && in_ready))
		else $error("push without accepted item");
`endif

endmodule

/* bench/testbench.sv */
// testbench for the sound region detector: queued sample stimulus, group prediction, checks
module testbench import srd_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	// cycles without any handshake before the run is declared hung
	localparam int STALL_LIMIT = 4000;
	// random samples queued per configuration phase
	localparam int PHASE_ITEMS = 190;
	localparam int PHASES      = 9;

	typedef struct {
		logic [IN_BITS-1:0] value;
		logic               last;
	} sample_item_t;

	typedef struct {
		logic [OUT_BITS-1:0] first_idx;
		logic [OUT_BITS-1:0] final_idx;
		logic                closes;
	} group_item_t;

	// dut ports, every input known from time zero
	logic                     clk          = 1'b0;
	logic                     arst_n       = 1'b0;
	logic                     cfg_valid    = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_BITS-1:0]  cfg_index    = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data     = '0;
	logic                     in_valid     = 1'b0;
	logic                     in_ready;
	logic [IN_BITS-1:0]       sample_value = '0;
	logic                     stream_end   = 1'b0;
	logic                     out_valid;
	logic                     out_ready    = 1'b0;
	logic [OUT_BITS-1:0]      group_first;
	logic [OUT_BITS-1:0]      group_final;
	logic                     run_last;

	// samples waiting for the driver, groups waiting for the monitor
	sample_item_t sample_backlog[$];
	group_item_t  expected_groups[$];
	int           queued_total = 0;
	int           fault_count  = 0;
	int           idle_cycles  = 0;

	// predictor copy of the registers
	logic [THR_BITS-1:0] thr_cfg = NOISE_RESET;
	logic [GAP_BITS-1:0] gap_cfg = GAP_RESET;

	// predictor copy of the region state
	logic [INDEX_BITS-1:0] next_idx     = '0;
	logic                  sounding     = 1'b0;
	logic [INDEX_BITS-1:0] region_start = '0;
	logic [INDEX_BITS-1:0] region_end   = '0;
	logic [INDEX_BITS-1:0] group_start  = '0;
	logic                  group_active = 1'b0;

	// sender burst state and receiver stall pattern state
	int           burst_left = 1;
	int           gap_left   = 0;
	sample_item_t next_item;
	int           stall_mode = 0;
	int           stall_left = 0;

	// configuration of each phase, random entries filled in at run time
	int unsigned phase_thr[PHASES] = '{0, 32768, 0, 100, 32767, 0, 0, 0, 400};
	int unsigned phase_gap[PHASES] = '{0, 16777215, 1, 2, 5, 0, 0, 0, 10000};

	sound_region_detector_unit uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.sample_value(sample_value),
		.stream_end  (stream_end),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.group_first (group_first),
		.group_final (group_final),
		.run_last    (run_last)
	);

	always #10 clk = ~clk;

	task automatic flag_fault(input string what);
		if (fault_count < 10) begin
			$display("%0t: %s", $realtime, what);
		end
		fault_count++;
	endtask

	// one accepted sample: classify it, update region state, queue the groups it closes
	function automatic void track_sample(input logic [IN_BITS-1:0] value, input logic closing);
		logic [SAMPLE_BITS:0]   mag;
		logic [INDEX_BITS-1:0]  idx;
		logic [SUM_BITS-1:0]    reach;
		group_item_t            found[$];
		group_item_t            g;
		mag = value[SAMPLE_BITS-1] ?
			(((SAMPLE_BITS+1)'(1) << SAMPLE_BITS) - (SAMPLE_BITS+1)'(value[SAMPLE_BITS-1:0])) :
			(SAMPLE_BITS+1)'(value[SAMPLE_BITS-1:0]);
		idx = next_idx;
		if (mag > thr_cfg) begin
			// a loud sample only matters when it opens a region
			if (!sounding) begin
				region_start = idx;
				sounding     = 1'b1;
				reach        = SUM_BITS'(region_end) + SUM_BITS'(gap_cfg);
				if (!group_active) begin
					group_start  = idx;
					group_active = 1'b1;
				end else if (SUM_BITS'(idx) > reach) begin
					// distant region: the open group closes at the previous region's end
					g.first_idx = OUT_BITS'(group_start);
					g.final_idx = OUT_BITS'(region_end);
					g.closes    = 1'b0;
					found.insert(found.size(), g);
					group_start = idx;
				end
			end
		end else if (sounding) begin
			// region ends on the sample before this quiet one, never before its start
			region_end = (idx > region_start) ? idx - 1'b1 : region_start;
			sounding   = 1'b0;
		end
		if (closing) begin
			if (sounding) begin
				region_end = idx;
			end
			if (group_active) begin
				g.first_idx = OUT_BITS'(group_start);
				g.final_idx = OUT_BITS'(region_end);
				g.closes    = 1'b0;
				found.insert(found.size(), g);
			end
			next_idx     = '0;
			sounding     = 1'b0;
			region_start = '0;
			region_end   = '0;
			group_start  = '0;
			group_active = 1'b0;
		end else if (idx != IDX_MAX) begin
			// index sticks at its top value
			next_idx = idx + 1'b1;
		end
		if (found.size() > 0) begin
			found[found.size()-1].closes = 1'b1;
		end
		foreach (found[k]) begin
			expected_groups.insert(expected_groups.size(), found[k]);
		end
	endfunction

	function automatic void queue_sample(input logic [IN_BITS-1:0] value, input logic last);
		sample_item_t s;
		s.value = value;
		s.last  = last;
		sample_backlog.insert(sample_backlog.size(), s);
		queued_total++;
	endfunction

	// a sample that is loud or quiet under the current threshold, extremes now and then
	function automatic logic [IN_BITS-1:0] make_sample(input bit loud);
		int unsigned        mag;
		int unsigned        top;
		logic [IN_BITS-1:0] v;
		top = (thr_cfg > 32768) ? 32768 : thr_cfg;
		if (loud && thr_cfg < 32768) begin
			mag = ($urandom_range(0, 7) == 0) ? thr_cfg + 1 : $urandom_range(32768, thr_cfg + 1);
		end else if (loud) begin
			mag = 32768;
		end else begin
			mag = ($urandom_range(0, 7) == 0) ? top : $urandom_range(top, 0);
		end
		if (mag >= 32768) begin
			return IN_BITS'(16'h8000);
		end
		v = IN_BITS'(mag);
		if ($urandom_range(0, 1) == 1) begin
			v = -v;
		end
		return v;
	endfunction

	// a well-formed recording: loud runs separated by quiet stretches near the merge distance
	task automatic queue_recording();
		sample_item_t seq[$];
		sample_item_t s;
		int           regions;
		int           lead;
		int           run;
		int           quiet;
		regions = $urandom_range(0, 4);
		lead    = $urandom_range(0, 3);
		if (regions == 0 && lead == 0) begin
			lead = 1;
		end
		s.last = 1'b0;
		repeat (lead) begin
			s.value = make_sample(1'b0);
			seq.insert(seq.size(), s);
		end
		for (int k = 0; k < regions; k++) begin
			run = $urandom_range(1, 6);
			repeat (run) begin
				s.value = make_sample(1'b1);
				seq.insert(seq.size(), s);
			end
			if (k < regions - 1) begin
				// gap-1, gap and gap+1 quiet samples straddle the merge decision
				if (gap_cfg <= 64 && $urandom_range(0, 1) == 1) begin
					quiet = int'(gap_cfg) - 1 + $urandom_range(0, 2);
				end else begin
					quiet = $urandom_range(1, 8);
				end
				if (quiet < 1) begin
					quiet = 1;
				end
			end else begin
				quiet = $urandom_range(0, 3);
			end
			repeat (quiet) begin
				s.value = make_sample(1'b0);
				seq.insert(seq.size(), s);
			end
		end
		// most recordings close, the rest run on into the next one
		seq[seq.size()-1].last = ($urandom_range(0, 3) != 0);
		foreach (seq[k]) begin
			queue_sample(seq[k].value, seq[k].last);
		end
	endtask

	// raw noise: any bit pattern, stream end now and then
	task automatic queue_noise();
		repeat ($urandom_range(1, 10)) begin
			queue_sample(IN_BITS'($urandom_range(0, 65535)), $urandom_range(0, 15) == 0);
		end
	endtask

	task automatic write_reg(input srd_reg_t which, input logic [CFG_DATA_BITS-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= which;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		unique case (which)
			REG_NOISE_THRESHOLD: thr_cfg = data[THR_BITS-1:0];
			REG_MERGE_GAP:       gap_cfg = data[GAP_BITS-1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	// block is idle once all samples are in and all groups out, plus margin for silent items
	task automatic wait_idle();
		do @(negedge clk);
		while (sample_backlog.size() != 0 || in_valid || expected_groups.size() != 0);
		repeat (10) @(negedge clk);
	endtask

	// sender: bursts of random length, random gaps between them
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				track_sample(sample_value, stream_end);
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left = gap_left - 1;
					in_valid <= 1'b0;
				end else if (sample_backlog.size() > 0) begin
					next_item = sample_backlog.pop_front();
					in_valid     <= 1'b1;
					sample_value <= next_item.value;
					stream_end   <= next_item.last;
					burst_left = burst_left - 1;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: stall pattern switches to a new random mode each time its stall_left count runs out
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (stall_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_left = $urandom_range(20, 200);
			end else begin
				stall_left = stall_left - 1;
			end
			unique case (stall_mode)
				0:       out_ready <= 1'b1;
				1:       out_ready <= ($urandom_range(0, 1) == 1);
				2:       out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// monitor: every accepted group against the oldest expected one
	always @(posedge clk) begin
		group_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_groups.size() == 0) begin
				flag_fault($sformatf("unexpected group: first %0d final %0d last %b",
					group_first, group_final, run_last));
			end else begin
				want = expected_groups.pop_front();
				if (group_first !== want.first_idx || group_final !== want.final_idx ||
				    run_last !== want.closes) begin
					flag_fault($sformatf(
						"group mismatch: expected first %0d final %0d last %b, got %0d %0d %b",
						want.first_idx, want.final_idx, want.closes,
						group_first, group_final, run_last));
				end
			end
		end
	end

	// watchdog: any handshake restarts the count
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles = idle_cycles + 1;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		int goal;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset thresholds: magnitude equal to the threshold is quiet, one above is loud,
		// both extremes of the sample range, quiet end of stream closes a merged group
		queue_sample(16'd0, 1'b0);
		queue_sample(16'd401, 1'b0);
		queue_sample(16'h8000, 1'b0);
		queue_sample(-16'sd400, 1'b0);
		queue_sample(16'h7fff, 1'b0);
		queue_sample(16'd400, 1'b0);
		queue_sample(16'hffff, 1'b1);
		// single loud sample that is also the end of stream
		queue_sample(16'h8000, 1'b1);
		// end of stream with no sound at all
		queue_sample(16'd5, 1'b1);
		// region still running at end of stream
		queue_sample(-16'sd401, 1'b0);
		queue_sample(-16'sd401, 1'b1);
		wait_idle();

		// zero threshold and tight merge distance: distant regions, a merge at exactly
		// the gap, and a distant region starting on the last sample (two groups at once)
		write_reg(REG_NOISE_THRESHOLD, CFG_DATA_BITS'(0));
		write_reg(REG_MERGE_GAP, CFG_DATA_BITS'(2));
		queue_sample(16'd5, 1'b0);
		queue_sample(16'd0, 1'b0);
		queue_sample(16'd0, 1'b0);
		queue_sample(16'd7, 1'b0);
		queue_sample(16'd0, 1'b0);
		queue_sample(16'd0, 1'b0);
		queue_sample(16'hffff, 1'b0);
		queue_sample(16'd0, 1'b0);
		queue_sample(16'd1, 1'b0);
		queue_sample(16'd0, 1'b0);
		queue_sample(16'd0, 1'b0);
		queue_sample(16'd0, 1'b0);
		queue_sample(16'd1, 1'b1);
		wait_idle();

		// random phases, register extremes among them
		for (int p = 0; p < PHASES; p++) begin
			if (p >= 5 && p <= 7) begin
				phase_thr[p] = $urandom_range(0, 32768);
				phase_gap[p] = (p == 7) ? $urandom_range(0, 1000) : $urandom_range(0, 40);
			end
			write_reg(REG_NOISE_THRESHOLD, CFG_DATA_BITS'(phase_thr[p]));
			write_reg(REG_MERGE_GAP, CFG_DATA_BITS'(phase_gap[p]));
			goal = queued_total + PHASE_ITEMS;
			while (queued_total < goal) begin
				if ($urandom_range(0, 4) == 0) begin
					queue_noise();
				end else begin
					queue_recording();
				end
			end
			wait_idle();
		end

		repeat (20) @(negedge clk);
		if (fault_count == 0 && expected_groups.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
